FILE: rtl/dq_pkg.sv
// Shared types and codes for the double-ended queue.
package dq_pkg;

   typedef enum logic [2:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_BACK   = 3'd2,
      ACT_POP_FRONT  = 3'd3,
      ACT_PEEK_BACK  = 3'd4,
      ACT_PEEK_FRONT = 3'd5,
      ACT_CLEAR      = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   localparam int unsigned ACTION_W = 3;
   localparam int unsigned PORT_W   = 32;
   localparam int unsigned STATUS_W = 2;

endpackage

FILE: rtl/dq_ram.sv
// Element store: one write port, one registered read port.
module dq_ram #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned WIDTH = 32,
   parameter int unsigned AW    = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dq_ctrl.sv
// Action decode, head/tail pointers, fill count and result status.
module dq_ctrl #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned WIDTH = 32,
   parameter int unsigned AW    = 8,
   parameter int unsigned CW    = 9
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [dq_pkg::ACTION_W-1:0] req_action,
   input  logic [dq_pkg::PORT_W-1:0]   req_value,
   output logic                        mem_wr_en,
   output logic [AW-1:0]               mem_wr_addr,
   output logic [WIDTH-1:0]            mem_wr_data,
   output logic                        mem_rd_en,
   output logic [AW-1:0]               mem_rd_addr,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic [dq_pkg::STATUS_W-1:0] rsp_status,
   output logic [CW-1:0]               rsp_count
);
   import dq_pkg::*;

   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   logic             busy_ff;
   logic [AW-1:0]    head_ff, head_in;
   logic [AW-1:0]    tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             valid_ff;
   logic             hit_ff, hit_in;
   status_type       status_ff, status_in;
   logic             accept;
   action_type       act;
   logic             full, empty;
   logic [AW-1:0]    head_next, head_prev, tail_prev;
   logic [2*PORT_W-1:0] value_ext;

   assign accept    = start && !busy_ff;
   assign act       = action_type'(req_action);
   assign full      = (count_ff == FULL_CNT);
   assign empty     = (count_ff == '0);
   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + AW'(1);
   assign head_prev = (head_ff == '0) ? LAST_IDX : head_ff - AW'(1);
   assign tail_prev = (tail_ff == '0) ? LAST_IDX : tail_ff - AW'(1);
   assign value_ext = {{PORT_W{1'b0}}, req_value};

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      status_in   = ST_OK;
      hit_in      = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = tail_ff;
      mem_wr_data = value_ext[WIDTH-1:0];
      mem_rd_en   = 1'b0;
      mem_rd_addr = head_ff;
      if (accept) begin
         case (act)
            ACT_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  mem_wr_en = 1'b1;
                  tail_in   = (tail_ff == LAST_IDX) ? '0 : tail_ff + AW'(1);
                  count_in  = count_ff + CW'(1);
               end
            end
            ACT_PUSH_FRONT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = head_prev;
                  head_in     = head_prev;
                  count_in    = count_ff + CW'(1);
               end
            end
            ACT_POP_BACK, ACT_PEEK_BACK, ACT_POP_FRONT, ACT_PEEK_FRONT: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  hit_in    = 1'b1;
                  mem_rd_en = 1'b1;
                  if (act inside {ACT_POP_BACK, ACT_PEEK_BACK}) begin
                     mem_rd_addr = tail_prev;
                  end
                  if (act == ACT_POP_BACK) begin
                     tail_in  = tail_prev;
                     count_in = count_ff - CW'(1);
                  end else if (act == ACT_POP_FRONT) begin
                     head_in  = head_next;
                     count_in = count_ff - CW'(1);
                  end
               end
            end
            ACT_CLEAR: begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= 1'b0;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff    <= hit_in;
         status_ff <= status_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_valid  = valid_ff;
   assign rsp_hit    = hit_ff;
   assign rsp_status = status_ff;
   assign rsp_count  = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("fill count above depth");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff == ST_FULL) |-> (count_ff == FULL_CNT))
      else $error("full status with room left");

   a_empty_means_empty: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff == ST_EMPTY) |-> (count_ff == '0))
      else $error("empty status with elements held");

   a_hit_is_ok: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && hit_ff) |-> (status_ff == ST_OK && count_ff != '0
         || status_ff == ST_OK && $past(count_ff) == CW'(1)))
      else $error("read hit on an error result");

endmodule

FILE: rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue.
// A result strobes on rsp_valid for one cycle; rsp_valid is registered from the accept of its word.
// Throughput: one word per cycle; busy never rises during operation.
// The element store is a one-port-write, registered-read memory: each word does at most one access.
// Reset: pointers and count return to zero; busy is high in reset and stays high into the cycle after it.
// The receiver cannot stall; no clearing pass runs, store contents stay undefined.
module double_ended_queue #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned WIDTH = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [dq_pkg::ACTION_W-1:0]              req_action,
   input  logic [dq_pkg::PORT_W-1:0]                req_value,
   output logic                                     rsp_valid,
   output logic [dq_pkg::PORT_W-1:0]                rsp_data,
   output logic [dq_pkg::STATUS_W-1:0]              rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]               rsp_count
);
   import dq_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   logic [WIDTH-1:0] mem_wr_data;
   logic             mem_rd_en;
   logic [AW-1:0]    mem_rd_addr;
   logic [WIDTH-1:0] mem_rd_data;
   logic             rsp_hit;
   logic [63:0]      rd_ext;

   // Pointers and count advance at the accepting edge, and the store write lands on
   // that same edge. A following word that reads the same entry issues its read at a
   // later edge, so it always sees the new element: no forwarding path is needed.
   dq_ctrl #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_action  (req_action),
      .req_value   (req_value),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .rsp_valid   (rsp_valid),
      .rsp_hit     (rsp_hit),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count)
   );

   // Hold the elements; the read register holds the popped or peeked word for the result cycle.
   dq_ram #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Drop the read data to zero unless this result is a successful pop or peek.
   assign rd_ext   = 64'(mem_rd_data);
   assign rsp_data = rsp_hit ? rd_ext[PORT_W-1:0] : '0;

   a_busy_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> busy)
      else $error("busy low right after reset");

   a_result_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(start && !busy))
      else $error("result strobe not one cycle after accept");

   a_error_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_data == '0))
      else $error("error result carries data");

endmodule
